// File: hdl/cpbd_pkg.sv
package cpbd_pkg;

   localparam int DRIVE_LIMIT = 4096;
   localparam int AVG_TAPS    = 5;

   localparam int RATE_W  = 16;
   localparam int COUNT_W = 13;
   localparam int DUTY_W  = 13;

   localparam int CFG_NUM   = 8;
   localparam int CFG_IDX_W = 3;
   localparam int CFG_W     = 16;

   localparam logic [CFG_IDX_W-1:0] CFG_OUTER_P = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_OUTER_I = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_OUTER_D = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_P = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_I = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_D = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_BIAS    = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_C2S     = 3'd7;

   localparam logic [CFG_W-1:0] RST_OUTER_P = 16'(-1280);
   localparam logic [CFG_W-1:0] RST_OUTER_I = 16'(-77);
   localparam logic [CFG_W-1:0] RST_OUTER_D = 16'(-512);
   localparam logic [CFG_W-1:0] RST_WHEEL_P = 16'd2560;
   localparam logic [CFG_W-1:0] RST_WHEEL_I = 16'd2048;
   localparam logic [CFG_W-1:0] RST_WHEEL_D = 16'd1280;
   localparam logic [CFG_W-1:0] RST_BIAS    = 16'd10;
   localparam logic [CFG_W-1:0] RST_C2S     = 16'd8742;

   // running history sum and divide-by-taps via reciprocal
   localparam int SUM_W   = RATE_W + $clog2(AVG_TAPS);
   localparam int MAG_W   = SUM_W + 4;
   localparam int DIV_L   = $clog2(AVG_TAPS);
   localparam int DIV_SH  = MAG_W + DIV_L;
   localparam int RECIP_W = DIV_SH + 1;
   localparam int DPROD_W = MAG_W + RECIP_W;
   localparam int TAPS_W  = $clog2(AVG_TAPS + 1);
   localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SH) / AVG_TAPS);
   localparam int AVG_W   = MAG_W + 1;
   localparam int OERR_W  = AVG_W + 1;

   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 52;
   localparam int DRIVE_W = $clog2(DRIVE_LIMIT + 1) + 1;

   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_OUT_P = 3'd0;
   localparam logic [OP_W-1:0] OP_OUT_I = 3'd1;
   localparam logic [OP_W-1:0] OP_OUT_D = 3'd2;
   localparam logic [OP_W-1:0] OP_SPEED = 3'd3;
   localparam logic [OP_W-1:0] OP_W_P   = 3'd4;
   localparam logic [OP_W-1:0] OP_W_I   = 3'd5;
   localparam logic [OP_W-1:0] OP_W_D   = 3'd6;

   typedef struct packed {
      logic              load;
      logic              gyro_step;
      logic              div_mul;
      logic              div_fix;
      logic              outer_upd;
      logic              mul_en;
      logic              acc_en;
      logic              acc_clr;
      logic              speed_upd;
      logic              werr_upd;
      logic              drive_upd;
      logic              out_load;
      logic [OP_W-1:0]   op;
      logic              wheel;
   } cmd_type;

   typedef struct packed {
      logic gyro_valid;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic signed [RATE_W-1:0]  gyro_rate;
      logic                      gyro_valid;
      logic signed [COUNT_W-1:0] left_count;
      logic signed [COUNT_W-1:0] right_count;
   } req_beat_type;

   typedef struct packed {
      logic [DUTY_W-1:0] left_duty;
      logic              left_reverse;
      logic [DUTY_W-1:0] right_duty;
      logic              right_reverse;
   } rsp_beat_type;

endpackage

// File: hdl/cpbd_channels.sv
interface cpbd_req_if;
   import cpbd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [RATE_W-1:0]  gyro_rate;
   logic                      gyro_valid;
   logic signed [COUNT_W-1:0] left_count;
   logic signed [COUNT_W-1:0] right_count;

   modport source (output valid, output gyro_rate, output gyro_valid,
                   output left_count, output right_count, input ready);
   modport sink   (input valid, input gyro_rate, input gyro_valid,
                   input left_count, input right_count, output ready);
endinterface

interface cpbd_rsp_if;
   import cpbd_pkg::*;

   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] left_duty;
   logic              left_reverse;
   logic [DUTY_W-1:0] right_duty;
   logic              right_reverse;

   modport source (output valid, output left_duty, output left_reverse,
                   output right_duty, output right_reverse, input ready);
   modport sink   (input valid, input left_duty, input left_reverse,
                   input right_duty, input right_reverse, output ready);
endinterface

// File: hdl/cpbd_ctrl.sv
module cpbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cpbd_pkg::status_type status,
   output cpbd_pkg::cmd_type    cmd
);
   import cpbd_pkg::*;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_GYRO      = 4'd1;
   localparam logic [3:0] ST_DIV_MUL   = 4'd2;
   localparam logic [3:0] ST_DIV_FIX   = 4'd3;
   localparam logic [3:0] ST_OUTER     = 4'd4;
   localparam logic [3:0] ST_MUL       = 4'd5;
   localparam logic [3:0] ST_ACC       = 4'd6;
   localparam logic [3:0] ST_SPEED_CMD = 4'd7;
   localparam logic [3:0] ST_WHEEL_ERR = 4'd8;
   localparam logic [3:0] ST_DRIVE     = 4'd9;
   localparam logic [3:0] ST_DONE      = 4'd10;

   logic [3:0]      state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic            wheel_ff, wheel_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      wheel_in = wheel_ff;
      cmd      = '0;
      cmd.op    = op_ff;
      cmd.wheel = wheel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GYRO;
            end
         end
         ST_GYRO: begin
            cmd.gyro_step = 1'b1;
            state_in = status.gyro_valid ? ST_DIV_MUL : ST_OUTER;
         end
         ST_DIV_MUL: begin
            cmd.div_mul = 1'b1;
            state_in = ST_DIV_FIX;
         end
         ST_DIV_FIX: begin
            cmd.div_fix = 1'b1;
            state_in = ST_OUTER;
         end
         ST_OUTER: begin
            cmd.outer_upd = 1'b1;
            cmd.acc_clr   = 1'b1;
            op_in    = OP_OUT_P;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in = (op_ff == OP_SPEED) ? ST_WHEEL_ERR : ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (op_ff == OP_OUT_D) begin
               state_in = ST_SPEED_CMD;
            end else if (op_ff == OP_W_D) begin
               state_in = ST_DRIVE;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_SPEED_CMD: begin
            cmd.speed_upd = 1'b1;
            op_in    = OP_SPEED;
            wheel_in = 1'b0;
            state_in = ST_MUL;
         end
         ST_WHEEL_ERR: begin
            cmd.werr_upd = 1'b1;
            cmd.acc_clr  = 1'b1;
            op_in    = OP_W_P;
            state_in = ST_MUL;
         end
         ST_DRIVE: begin
            cmd.drive_upd = 1'b1;
            if (!wheel_ff) begin
               wheel_in = 1'b1;
               op_in    = OP_SPEED;
               state_in = ST_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_OUT_P;
         wheel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         wheel_ff <= wheel_in;
      end
   end

endmodule

// File: hdl/cpbd_datapath.sv
module cpbd_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  cpbd_pkg::cmd_type               cmd,
   output cpbd_pkg::status_type            status,
   input  cpbd_pkg::req_beat_type          req_beat,
   output cpbd_pkg::rsp_beat_type          rsp_beat,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            csr_wr_en,
   input  logic [cpbd_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [cpbd_pkg::CFG_W-1:0]      csr_data
);
   import cpbd_pkg::*;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -48'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // configuration
   logic [CFG_W-1:0] cfg_ff [CFG_NUM];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CFG_OUTER_P] <= RST_OUTER_P;
         cfg_ff[CFG_OUTER_I] <= RST_OUTER_I;
         cfg_ff[CFG_OUTER_D] <= RST_OUTER_D;
         cfg_ff[CFG_WHEEL_P] <= RST_WHEEL_P;
         cfg_ff[CFG_WHEEL_I] <= RST_WHEEL_I;
         cfg_ff[CFG_WHEEL_D] <= RST_WHEEL_D;
         cfg_ff[CFG_BIAS]    <= RST_BIAS;
         cfg_ff[CFG_C2S]     <= RST_C2S;
      end else if (csr_wr_en) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // captured input beat
   req_beat_type in_ff;
   logic signed [COUNT_W-1:0] count_sel;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_beat;
      end
   end

   assign count_sel = cmd.wheel ? in_ff.right_count : in_ff.left_count;

   // gyro history with running sum
   logic signed [RATE_W-1:0] hist_ff [AVG_TAPS];
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [RATE_W:0]   biased;
   logic signed [RATE_W-1:0] sample;

   assign biased = (RATE_W+1)'(in_ff.gyro_rate) + (RATE_W+1)'($signed(cfg_ff[CFG_BIAS]));

   always_comb begin
      if (biased > 17'sd32767) begin
         sample = 16'sh7FFF;
      end else if (biased < -17'sd32768) begin
         sample = 16'sh8000;
      end else begin
         sample = biased[RATE_W-1:0];
      end
   end

   assign sum_in = sum_ff + SUM_W'(sample) - SUM_W'(hist_ff[AVG_TAPS-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_TAPS; i++) begin
            hist_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (cmd.gyro_step && in_ff.gyro_valid) begin
         for (int i = 1; i < AVG_TAPS; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
         hist_ff[0] <= sample;
         sum_ff     <= sum_in;
      end
   end

   // average: |sum*16| / taps by reciprocal multiply, one correction step
   logic signed [SUM_W:0]           sum_ext, sum_abs;
   logic [MAG_W-1:0]                x_mag, q0, q_fix;
   logic [DPROD_W-1:0]              dprod_ff;
   logic [MAG_W+TAPS_W-1:0]         q0_t, rem;
   logic signed [AVG_W-1:0]         q_s, avg_ff;

   assign sum_ext = (SUM_W+1)'(sum_ff);
   assign sum_abs = (sum_ext < 0) ? -sum_ext : sum_ext;
   assign x_mag   = {sum_abs[SUM_W-1:0], 4'b0000};
   assign q0      = dprod_ff[DIV_SH +: MAG_W];
   assign q0_t    = (MAG_W+TAPS_W)'(q0) * (MAG_W+TAPS_W)'(AVG_TAPS);
   assign rem     = (MAG_W+TAPS_W)'(x_mag) - q0_t;
   assign q_fix   = (rem >= (MAG_W+TAPS_W)'(AVG_TAPS)) ? q0 + 1'b1 : q0;
   assign q_s     = $signed({1'b0, q_fix});

   always_ff @(posedge clock) begin
      if (cmd.div_mul) begin
         dprod_ff <= DPROD_W'(x_mag) * DPROD_W'(DIV_RECIP);
      end
   end

   // outer loop state
   logic signed [OERR_W-1:0]  e_o, oprev_ff;
   logic signed [31:0]        oint_ff, cmd_ff;
   logic signed [MUL_B_W-1:0] dterm_ff, err_ext;
   logic signed [31:0]        err_ff;

   assign e_o = -(OERR_W'(avg_ff));

   // shared multiplier and accumulator
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [31:0]        wint_ff [2];
   logic signed [31:0]        wprev_ff [2];
   logic                      acc_sub;

   always_comb begin
      case (cmd.op)
         OP_OUT_P: begin
            mul_a = MUL_A_W'($signed(cfg_ff[CFG_OUTER_P]));
            mul_b = MUL_B_W'(avg_ff);
         end
         OP_OUT_I: begin
            mul_a = MUL_A_W'($signed(cfg_ff[CFG_OUTER_I]));
            mul_b = MUL_B_W'(oint_ff);
         end
         OP_OUT_D: begin
            mul_a = MUL_A_W'($signed(cfg_ff[CFG_OUTER_D]));
            mul_b = dterm_ff;
         end
         OP_SPEED: begin
            mul_a = $signed({1'b0, cfg_ff[CFG_C2S]});
            mul_b = MUL_B_W'(count_sel);
         end
         OP_W_P: begin
            mul_a = MUL_A_W'($signed(cfg_ff[CFG_WHEEL_P]));
            mul_b = MUL_B_W'(err_ff);
         end
         OP_W_I: begin
            mul_a = MUL_A_W'($signed(cfg_ff[CFG_WHEEL_I]));
            mul_b = MUL_B_W'(wint_ff[cmd.wheel]);
         end
         OP_W_D: begin
            mul_a = MUL_A_W'($signed(cfg_ff[CFG_WHEEL_D]));
            mul_b = dterm_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign acc_sub = (cmd.op == OP_OUT_D) || (cmd.op == OP_W_D);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_sub ? acc_ff - ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      end
   end

   // wheel error terms
   logic signed [PROD_W-1:0]  speed;
   logic signed [31:0]        err_w;
   logic signed [ACC_W-1:0]   cmd_shift, drv_shift;

   assign speed     = prod_ff >>> 4;
   assign err_w     = sat32(48'(cmd_ff) - 48'(speed));
   assign err_ext   = MUL_B_W'(err_w);
   assign cmd_shift = acc_ff >>> 8;
   assign drv_shift = acc_ff >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff      <= '0;
         oprev_ff    <= '0;
         oint_ff     <= '0;
         cmd_ff      <= '0;
         wint_ff[0]  <= '0;
         wint_ff[1]  <= '0;
         wprev_ff[0] <= '0;
         wprev_ff[1] <= '0;
      end else begin
         if (cmd.div_fix) begin
            avg_ff <= (sum_ff < 0) ? -q_s : q_s;
         end
         if (cmd.outer_upd) begin
            oprev_ff <= e_o;
            oint_ff  <= sat32(48'(oint_ff) + 48'(e_o));
         end
         if (cmd.speed_upd) begin
            cmd_ff <= sat32(48'(cmd_shift));
         end
         if (cmd.werr_upd) begin
            wint_ff[cmd.wheel]  <= sat32(48'(wint_ff[cmd.wheel]) + 48'(err_w));
            wprev_ff[cmd.wheel] <= err_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.outer_upd) begin
         dterm_ff <= MUL_B_W'(e_o) - MUL_B_W'(oprev_ff);
      end else if (cmd.werr_upd) begin
         dterm_ff <= err_ext - MUL_B_W'(wprev_ff[cmd.wheel]);
      end
      if (cmd.werr_upd) begin
         err_ff <= err_w;
      end
   end

   // drive clamp and split
   logic signed [ACC_W-1:0]   lim;
   logic signed [DRIVE_W-1:0] drive, drive_mag;
   logic [DUTY_W-1:0]         duty_ff [2];
   logic                      rev_ff [2];

   assign lim = ACC_W'(DRIVE_LIMIT);

   always_comb begin
      if (drv_shift > lim) begin
         drive = DRIVE_W'(lim);
      end else if (drv_shift < -lim) begin
         drive = DRIVE_W'(-lim);
      end else begin
         drive = DRIVE_W'(drv_shift);
      end
   end

   assign drive_mag = (drive < 0) ? -drive : drive;

   always_ff @(posedge clock) begin
      if (cmd.drive_upd) begin
         duty_ff[cmd.wheel] <= DUTY_W'($unsigned(drive_mag));
         rev_ff[cmd.wheel]  <= (drive < 0);
      end
   end

   // result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_beat.left_duty     <= duty_ff[0];
         rsp_beat.left_reverse  <= rev_ff[0];
         rsp_beat.right_duty    <= duty_ff[1];
         rsp_beat.right_reverse <= rev_ff[1];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;
   assign status.gyro_valid = in_ff.gyro_valid;

endmodule

// File: hdl/cascaded_pid_balance_drive_top.sv
// Cascaded PID balance drive. One beat on req_ch is one control tick: a gyro
// pitch-rate sample (used only when gyro_valid is set) and the two wheel encoder
// deltas; one beat on rsp_ch carries the duty magnitude and reverse flag of each
// wheel. The single shared 17x33 multiplier runs the outer loop's three products
// and, per wheel, the speed scaling and three products, each product a multiply
// step then an accumulate step; the speed scaling is not accumulated. A tick
// with a gyro sample also runs the divide states. A new tick is accepted while
// the previous result still waits on rsp_ch; the block stalls only when a
// finished result finds that register still occupied. Registers on csr_* are
// to be written while no tick is in flight; the block does not enforce this.
module cascaded_pid_balance_drive_top (
   input  logic                            clock,
   input  logic                            reset,
   cpbd_req_if.sink                        req_ch,
   cpbd_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [cpbd_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [cpbd_pkg::CFG_W-1:0]      csr_data
);
   import cpbd_pkg::*;

   cmd_type      cmd;
   status_type   status;
   req_beat_type req_beat;
   rsp_beat_type rsp_beat;
   logic         ready;

   assign req_ch.ready         = ready;
   assign req_beat.gyro_rate   = req_ch.gyro_rate;
   assign req_beat.gyro_valid  = req_ch.gyro_valid;
   assign req_beat.left_count  = req_ch.left_count;
   assign req_beat.right_count = req_ch.right_count;

   assign rsp_ch.left_duty     = rsp_beat.left_duty;
   assign rsp_ch.left_reverse  = rsp_beat.left_reverse;
   assign rsp_ch.right_duty    = rsp_beat.right_duty;
   assign rsp_ch.right_reverse = rsp_beat.right_reverse;

   cpbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpbd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_beat  (req_beat),
      .rsp_beat  (rsp_beat),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
